// ----- sv/clt_pkg.sv -----
// ----------------------------------------------------------------------------
// clt_pkg
// Shared constants for the command line tokenizer: parser modes, character
// codes and store geometry.
// ----------------------------------------------------------------------------
package clt_pkg;

  localparam int unsigned BUF_BYTES_DEF = 256;
  localparam int unsigned PTR_W         = 8;

  localparam logic [2:0] MODE_OPEN   = 3'd0;
  localparam logic [2:0] MODE_CLOSED = 3'd1;
  localparam logic [2:0] MODE_CMD    = 3'd2;
  localparam logic [2:0] MODE_QUOTE  = 3'd3;
  localparam logic [2:0] MODE_FULL   = 3'd4;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [7:0] START_CHAR_RST = 8'h2F;

endpackage

// ----- sv/clt_store.sv -----
// ----------------------------------------------------------------------------
// clt_store
// Single-port-write, single-port-read byte store with registered read data.
// ----------------------------------------------------------------------------
module clt_store
  import clt_pkg::*;
#(
  parameter int unsigned DEPTH = BUF_BYTES_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [7:0]        wdata,
  input  logic [AW-1:0]     raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/command_line_tokenizer_unit.sv -----
// ----------------------------------------------------------------------------
// command_line_tokenizer_unit
// Character-at-a-time command line tokenizer working in one byte store.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  in      | in_valid / in_stall    | action, rx_char, read_addr
//  out     | out_valid / out_stall  | accepted, line_done, parser_mode,
//          |                        | entry_count, read_data
//  cfg     | cfg_wr_en              | cfg_wr_data (start_char)
//
// Closing a token walks the store through the single read port for the space
// skip, the value search and the dash-removing shift. One transaction is in
// work at a time; a finished result sits in the output register while the
// next one is taken.
// Reset is synchronous; store contents are undefined until written.
// ----------------------------------------------------------------------------
module command_line_tokenizer_unit
  import clt_pkg::*;
#(
  parameter int unsigned BUF_BYTES = BUF_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       action,
  input  logic [7:0] rx_char,
  input  logic [7:0] read_addr,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       accepted,
  output logic       line_done,
  output logic [2:0] parser_mode,
  output logic [6:0] entry_count,
  output logic [7:0] read_data
);

  localparam int unsigned AW = $clog2(BUF_BYTES);
  localparam logic [PTR_W-1:0] TOP_RST = PTR_W'(BUF_BYTES - 2);

  typedef enum logic [16:0] {
    S_IDLE   = 17'h00001,
    S_EVAL   = 17'h00002,
    S_CT_BEG = 17'h00004,
    S_SKIPRD = 17'h00008,
    S_SKIPCK = 17'h00010,
    S_DASH2  = 17'h00020,
    S_SECCK  = 17'h00040,
    S_SECWT  = 17'h00080,
    S_SECEND = 17'h00100,
    S_SHRD   = 17'h00200,
    S_SHWR   = 17'h00400,
    S_PUSH0  = 17'h00800,
    S_PUSH1  = 17'h01000,
    S_CTRET  = 17'h02000,
    S_LFEND  = 17'h04000,
    S_FIN    = 17'h08000,
    S_SPARE  = 17'h10000
  } state_t;

  state_t state;

  logic [7:0]       start_char;
  logic [2:0]       mode;
  logic [PTR_W-1:0] text_len, index_top, token_start;
  logic [PTR_W-1:0] ptr, ent_name, ent_offs;
  logic [PTR_W:0]   sec;
  logic             req_act;
  logic [7:0]       req_ch, req_addr;
  logic             ctx_lf, ct_ok;
  logic             res_acc, res_done;
  logic [7:0]       res_data;

  logic             mem_we;
  logic [PTR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]       mem_wdata, mem_rdata;

  logic             in_fire, out_load;
  logic [PTR_W:0]   tl9, it9, ts9;
  logic             has_prev;
  logic [PTR_W:0]   cnt_span;

  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_load = (state == S_FIN) && (!out_valid || !out_stall);

  assign tl9      = {1'b0, text_len};
  assign it9      = {1'b0, index_top};
  assign ts9      = {1'b0, token_start};
  assign has_prev = (text_len != '0);
  assign cnt_span = (PTR_W+1)'(BUF_BYTES) - it9;

  clt_store #(.DEPTH(BUF_BYTES), .AW(AW)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr[AW-1:0]),
    .wdata (mem_wdata),
    .raddr (mem_raddr[AW-1:0]),
    .rdata (mem_rdata)
  );

  // store port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    unique case (state)
      S_IDLE: begin
        mem_raddr = action ? read_addr : text_len - 1'b1;
      end
      S_EVAL: begin
        mem_waddr = text_len;
        mem_wdata = req_ch;
        if (!req_act && req_ch != CH_CR && req_ch != CH_LF) begin
          if (mode == MODE_CMD) begin
            mem_we = !(req_ch == CH_QUOTE && !(has_prev && mem_rdata == CH_BSL)) &&
                     !(req_ch == CH_SPACE && has_prev && mem_rdata != CH_SPACE) &&
                     (tl9 <= it9);
          end else if (mode == MODE_QUOTE) begin
            mem_we = !(req_ch == CH_QUOTE && !(has_prev && mem_rdata == CH_BSL)) &&
                     (tl9 + 1'b1 < it9);
          end
        end
      end
      S_CT_BEG: begin
        mem_we    = (tl9 < it9);
        mem_waddr = text_len;
        mem_wdata = CH_NUL;
      end
      S_SKIPRD: mem_raddr = token_start;
      S_SKIPCK: mem_raddr = token_start + 1'b1;
      S_SECCK:  mem_raddr = sec[PTR_W-1:0];
      S_SHRD:   mem_raddr = ptr;
      S_SHWR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr - PTR_W'(2);
        mem_wdata = mem_rdata;
      end
      S_PUSH0: begin
        mem_we    = 1'b1;
        mem_waddr = index_top;
        mem_wdata = ent_name;
      end
      S_PUSH1: begin
        mem_we    = 1'b1;
        mem_waddr = index_top + 1'b1;
        mem_wdata = ent_offs;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      start_char  <= START_CHAR_RST;
      mode        <= MODE_OPEN;
      text_len    <= '0;
      index_top   <= TOP_RST;
      token_start <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_wr_en) start_char <= cfg_wr_data;

      if (out_load) begin
        out_valid   <= 1'b1;
        accepted    <= res_acc;
        line_done   <= res_done;
        read_data   <= res_data;
        parser_mode <= mode;
        entry_count <= 7'(cnt_span[PTR_W:1] - 1'b1);
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            req_act  <= action;
            req_ch   <= rx_char;
            req_addr <= read_addr;
            res_acc  <= 1'b0;
            res_done <= 1'b0;
            res_data <= '0;
            state    <= S_EVAL;
          end
        end
        S_EVAL: begin
          state <= S_FIN;
          if (req_act) begin
            if ({1'b0, req_addr} < (PTR_W+1)'(BUF_BYTES)) res_data <= mem_rdata;
          end else if (req_ch == CH_CR) begin
            res_acc <= 1'b0;
          end else if (req_ch == CH_LF) begin
            ctx_lf <= 1'b1;
            if (mode == MODE_CMD && has_prev && mem_rdata != CH_SPACE) state <= S_CT_BEG;
            else state <= S_LFEND;
          end else begin
            unique case (mode)
              MODE_OPEN: begin
                if (req_ch == start_char) begin
                  mode        <= MODE_CMD;
                  token_start <= '0;
                  text_len    <= '0;
                  index_top   <= TOP_RST;
                  res_acc     <= 1'b1;
                end else begin
                  mode <= MODE_CLOSED;
                end
              end
              MODE_CMD: begin
                priority if (req_ch == CH_QUOTE && !(has_prev && mem_rdata == CH_BSL)) begin
                  mode    <= MODE_QUOTE;
                  res_acc <= 1'b1;
                end else if (req_ch == CH_SPACE && has_prev && mem_rdata != CH_SPACE) begin
                  ctx_lf <= 1'b0;
                  state  <= S_CT_BEG;
                end else if (tl9 <= it9) begin
                  text_len <= text_len + 1'b1;
                  res_acc  <= 1'b1;
                end else begin
                  mode <= MODE_FULL;
                end
              end
              MODE_QUOTE: begin
                res_acc <= 1'b1;
                priority if (req_ch == CH_QUOTE && !(has_prev && mem_rdata == CH_BSL)) begin
                  mode <= MODE_CMD;
                end else if (tl9 + 1'b1 < it9) begin
                  text_len <= text_len + 1'b1;
                end else begin
                  mode <= MODE_FULL;
                end
              end
              MODE_FULL: res_acc <= 1'b1;
              default:   res_acc <= 1'b0;
            endcase
          end
        end
        S_CT_BEG: begin
          if (tl9 < it9) begin
            text_len <= text_len + 1'b1;
            state    <= S_SKIPRD;
          end else begin
            ct_ok <= 1'b0;
            state <= S_CTRET;
          end
        end
        S_SKIPRD: state <= S_SKIPCK;
        S_SKIPCK: begin
          priority if (ts9 + 1'b1 < tl9 && mem_rdata == CH_SPACE) begin
            token_start <= token_start + 1'b1;
            state       <= S_SKIPRD;
          end else if (mem_rdata != CH_DASH) begin
            ent_name <= token_start;
            ent_offs <= '0;
            ct_ok    <= 1'b0;
            state    <= (ts9 + 1'b1 >= it9) ? S_CTRET : S_PUSH0;
          end else if (ts9 + 1'b1 >= tl9) begin
            text_len <= token_start;
            ct_ok    <= 1'b0;
            state    <= S_CTRET;
          end else begin
            state <= S_DASH2;
          end
        end
        S_DASH2: begin
          if (mem_rdata != CH_DASH) begin
            ent_name <= token_start;
            ent_offs <= PTR_W'(1);
            ct_ok    <= 1'b0;
            state    <= (ts9 + 1'b1 >= it9) ? S_CTRET : S_PUSH0;
          end else begin
            sec   <= ts9 + (PTR_W+1)'(3);
            state <= S_SECCK;
          end
        end
        S_SECCK: begin
          if (sec + 1'b1 < tl9) begin
            state <= S_SECWT;
          end else begin
            sec   <= sec + 1'b1;
            state <= S_SECEND;
          end
        end
        S_SECWT: begin
          sec   <= sec + 1'b1;
          state <= (mem_rdata != CH_NUL) ? S_SECCK : S_SECEND;
        end
        S_SECEND: begin
          // long flag still waiting for its value
          priority if (sec == tl9) begin
            ct_ok <= 1'b1;
            state <= S_CTRET;
          end else if (ts9 + 1'b1 >= it9) begin
            ct_ok <= 1'b0;
            state <= S_CTRET;
          end else begin
            ptr   <= token_start + PTR_W'(2);
            state <= S_SHRD;
          end
        end
        S_SHRD: begin
          if (ptr < text_len) begin
            state <= S_SHWR;
          end else begin
            ent_name <= token_start;
            ent_offs <= PTR_W'(sec - (ts9 + (PTR_W+1)'(2)));
            text_len <= text_len - PTR_W'(2);
            state    <= S_PUSH0;
          end
        end
        S_SHWR: begin
          ptr   <= ptr + 1'b1;
          state <= S_SHRD;
        end
        S_PUSH0: state <= S_PUSH1;
        S_PUSH1: begin
          if (index_top >= PTR_W'(2)) index_top <= index_top - PTR_W'(2);
          token_start <= text_len;
          ct_ok       <= 1'b1;
          state       <= S_CTRET;
        end
        S_CTRET: begin
          if (!ct_ok) mode <= ctx_lf ? MODE_CLOSED : MODE_FULL;
          if (ctx_lf) begin
            state <= S_LFEND;
          end else begin
            res_acc <= 1'b1;
            state   <= S_FIN;
          end
        end
        S_LFEND: begin
          res_acc  <= (mode == MODE_CMD) || (mode == MODE_QUOTE);
          res_done <= (mode == MODE_CMD) || (mode == MODE_QUOTE);
          mode     <= MODE_OPEN;
          state    <= S_FIN;
        end
        S_FIN: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // index entries are two bytes, so the top pointer keeps its parity
  a_top_parity: assert property (@(posedge clk) disable iff (rst)
    index_top[0] == TOP_RST[0])
    else $error("index_top parity broken");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("store written while idle");

  a_done_acc: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!line_done || accepted))
    else $error("line_done without accepted");

  a_load_frees_core: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (state == S_IDLE) && out_valid)
    else $error("result load did not release the sequencer");

endmodule
